>>> rtl/core/lps_pkg.sv
// shared types and constants for the line pixel stepper
package lps_pkg;

    // frame size registers are 7 bits wide, enough to hold 64
    localparam int unsigned FRAME_BITS  = 7;
    localparam int unsigned COLOR_BITS  = 24;
    localparam logic [FRAME_BITS-1:0] FRAME_RESET = 7'd64;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // sequencer states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // per line step control handed to the step unit
    typedef struct packed {
        logic x_major;
        logic x_down;
        logic y_down;
    } t_step_ctrl;

endpackage

>>> rtl/core/lps_step_unit.sv
// one bresenham step: error update and coordinate move
module lps_step_unit #(
    parameter int unsigned COORD_BITS = 6
) (
    input  logic [COORD_BITS-1:0] i_cur_x,
    input  logic [COORD_BITS-1:0] i_cur_y,
    input  logic [COORD_BITS:0]   i_err,
    input  logic [COORD_BITS-1:0] i_major,
    input  logic [COORD_BITS-1:0] i_minor,
    input  lps_pkg::t_step_ctrl   i_ctrl,
    output logic [COORD_BITS-1:0] o_next_x,
    output logic [COORD_BITS-1:0] o_next_y,
    output logic [COORD_BITS:0]   o_next_err
);

    logic [COORD_BITS:0]   err_sum;
    logic [COORD_BITS:0]   major_ext;
    logic                  step_minor;
    logic                  step_x;
    logic                  step_y;
    logic [COORD_BITS-1:0] one;

    assign one       = {{(COORD_BITS-1){1'b0}}, 1'b1};
    assign major_ext = {1'b0, i_major};
    // err never exceeds major, so the sum fits without overflow
    assign err_sum    = i_err + {1'b0, i_minor};
    assign step_minor = err_sum > major_ext;
    assign o_next_err = step_minor ? (err_sum - major_ext) : err_sum;

    assign step_x = i_ctrl.x_major | step_minor;
    assign step_y = ~i_ctrl.x_major | step_minor;

    always_comb begin
        o_next_x = i_cur_x;
        o_next_y = i_cur_y;
        if (step_x) begin
            o_next_x = i_ctrl.x_down ? (i_cur_x - one) : (i_cur_x + one);
        end
        if (step_y) begin
            o_next_y = i_ctrl.y_down ? (i_cur_y - one) : (i_cur_y + one);
        end
    end

endmodule

>>> rtl/core/line_pixel_stepper.sv
// top level: bresenham line stepper with frame clip flag, one pixel per cycle
// the start point is registered and appears in the cycle after start is taken
// busy is high from the first point to the one before the last, so the next
//   line can start in the cycle its predecessor's last point is shown
// the step unit does one major-axis step each cycle while a line runs; results cannot be stalled
// reset (synchronous, active low) returns to idle and sets the frame to 64x64
module line_pixel_stepper #(
    parameter int unsigned COORD_BITS = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // line command
    input  logic                            start,
    output logic                            busy,
    input  logic [COORD_BITS-1:0]           i_start_x,
    input  logic [COORD_BITS-1:0]           i_start_y,
    input  logic [COORD_BITS-1:0]           i_end_x,
    input  logic [COORD_BITS-1:0]           i_end_y,
    input  logic [lps_pkg::COLOR_BITS-1:0]  i_pixel_color,
    // pixel results, one per strobe
    output logic                            o_strobe,
    output logic [COORD_BITS-1:0]           o_point_x,
    output logic [COORD_BITS-1:0]           o_point_y,
    output logic                            o_inside_res,
    output logic [lps_pkg::COLOR_BITS-1:0]  o_point_color,
    output logic                            o_last_point,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [lps_pkg::FRAME_BITS-1:0]  i_cfg_data
);

    localparam int unsigned FB = lps_pkg::FRAME_BITS;

    // sequencer
    lps_pkg::t_state r_state;
    lps_pkg::t_state n_state;

    // frame registers
    logic [FB-1:0] r_frame_w;
    logic [FB-1:0] r_frame_h;

    // line state
    logic [COORD_BITS-1:0]     r_cur_x;
    logic [COORD_BITS-1:0]     r_cur_y;
    logic [COORD_BITS:0]       r_err;
    logic [COORD_BITS-1:0]     r_steps;
    logic [COORD_BITS-1:0]     r_major;
    logic [COORD_BITS-1:0]     r_minor;
    lps_pkg::t_step_ctrl       r_ctrl;
    logic [lps_pkg::COLOR_BITS-1:0] r_color;

    // output register
    logic                      r_strobe;
    logic [COORD_BITS-1:0]     r_out_x;
    logic [COORD_BITS-1:0]     r_out_y;
    logic                      r_out_inside;
    logic                      r_out_last;

    // setup path for a new line
    logic                      accept;
    logic                      x_fwd;
    logic                      y_fwd;
    logic [COORD_BITS-1:0]     dx;
    logic [COORD_BITS-1:0]     dy;
    lps_pkg::t_step_ctrl       new_ctrl;
    logic [COORD_BITS-1:0]     new_major;
    logic [COORD_BITS-1:0]     new_minor;

    // step path
    logic [COORD_BITS-1:0]     nxt_x;
    logic [COORD_BITS-1:0]     nxt_y;
    logic [COORD_BITS:0]       nxt_err;
    logic                      step_last;

    // point selected for the output register this cycle
    logic [COORD_BITS-1:0]     pt_x;
    logic [COORD_BITS-1:0]     pt_y;
    logic                      pt_inside;

    logic [COORD_BITS-1:0]     one;
    assign one = {{(COORD_BITS-1){1'b0}}, 1'b1};

    assign accept = start & ~busy;

    // spans and directions; a coordinate steps down unless start is below end
    assign x_fwd = i_start_x < i_end_x;
    assign y_fwd = i_start_y < i_end_y;
    assign dx    = x_fwd ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
    assign dy    = y_fwd ? (i_end_y - i_start_y) : (i_start_y - i_end_y);

    // x is major only on a strict win, ties go to y
    assign new_ctrl.x_major = dx > dy;
    assign new_ctrl.x_down  = ~x_fwd;
    assign new_ctrl.y_down  = ~y_fwd;
    assign new_major = new_ctrl.x_major ? dx : dy;
    assign new_minor = new_ctrl.x_major ? dy : dx;

    lps_step_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_cur_x    (r_cur_x),
        .i_cur_y    (r_cur_y),
        .i_err      (r_err),
        .i_major    (r_major),
        .i_minor    (r_minor),
        .i_ctrl     (r_ctrl),
        .o_next_x   (nxt_x),
        .o_next_y   (nxt_y),
        .o_next_err (nxt_err)
    );

    // the step that takes the count to zero produces the last point
    assign step_last = r_steps == one;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lps_pkg::ST_IDLE: begin
                if (accept && (new_major != '0)) begin
                    n_state = lps_pkg::ST_RUN;
                end
            end
            lps_pkg::ST_RUN: begin
                if (step_last) begin
                    n_state = lps_pkg::ST_IDLE;
                end
            end
            default: n_state = lps_pkg::ST_IDLE;
        endcase
    end

    // state decoded outputs
    always_comb begin
        unique case (r_state)
            lps_pkg::ST_IDLE: busy = 1'b0;
            lps_pkg::ST_RUN:  busy = 1'b1;
            default:          busy = 1'b0;
        endcase
    end

    // point going to the output register: start point on accept, else the step
    assign pt_x = busy ? nxt_x : i_start_x;
    assign pt_y = busy ? nxt_y : i_start_y;
    assign pt_inside = ({{(FB-COORD_BITS){1'b0}}, pt_x} < r_frame_w) &&
                       ({{(FB-COORD_BITS){1'b0}}, pt_y} < r_frame_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lps_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= accept | busy;
        end
    end

    // line state and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur_x <= i_start_x;
            r_cur_y <= i_start_y;
            r_err   <= {2'b00, new_major[COORD_BITS-1:1]};
            r_steps <= new_major;
            r_major <= new_major;
            r_minor <= new_minor;
            r_ctrl  <= new_ctrl;
            r_color <= i_pixel_color;
        end else if (busy) begin
            r_cur_x <= nxt_x;
            r_cur_y <= nxt_y;
            r_err   <= nxt_err;
            r_steps <= r_steps - one;
        end
        if (accept || busy) begin
            r_out_x      <= pt_x;
            r_out_y      <= pt_y;
            r_out_inside <= pt_inside;
            r_out_last   <= busy ? step_last : (new_major == '0);
        end
    end

    // configuration transfer, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= lps_pkg::FRAME_RESET;
            r_frame_h <= lps_pkg::FRAME_RESET;
        end else if (i_cfg_valid) begin
            unique case (lps_pkg::t_cfg_reg'(i_cfg_index))
                lps_pkg::CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                lps_pkg::CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_point_x     = r_out_x;
    assign o_point_y     = r_out_y;
    assign o_inside_res  = r_out_inside;
    assign o_point_color = r_color;
    assign o_last_point  = r_out_last;

endmodule

>>> bench/tb_line_pixel_stepper.sv
// self-checking bench for the line pixel stepper: directed and random lines against a line predictor
module tb_line_pixel_stepper;

    localparam int unsigned COORD_BITS   = 6;
    // cycles with no transfer of any kind before the run is declared hung
    localparam int unsigned STALL_LIMIT  = 4000;
    // extra cycles after the last pixel before touching registers or ending
    localparam int unsigned DRAIN_CYCLES = 4;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [lps_pkg::FRAME_BITS-1:0] t_frame;
    typedef logic [lps_pkg::COLOR_BITS-1:0] t_color;

    // one pixel write as the block should present it
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   in_frame;
        t_color color;
        logic   last;
    } t_pixel;

    // clock and reset
    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;

    // line command side, all driven to known values from time zero
    logic   start         = 1'b0;
    logic   busy;
    t_coord i_start_x     = '0;
    t_coord i_start_y     = '0;
    t_coord i_end_x       = '0;
    t_coord i_end_y       = '0;
    t_color i_pixel_color = '0;

    // pixel result side
    logic   o_strobe;
    t_coord o_point_x;
    t_coord o_point_y;
    logic   o_inside_res;
    t_color o_point_color;
    logic   o_last_point;

    // register write channel
    logic   i_cfg_valid = 1'b0;
    logic   o_cfg_ready;
    logic   i_cfg_index = lps_pkg::CFG_FRAME_WIDTH;
    t_frame i_cfg_data  = '0;

    // predictor copy of the frame registers, reset values
    t_frame frame_w = lps_pkg::FRAME_RESET;
    t_frame frame_h = lps_pkg::FRAME_RESET;

    // pixels predicted but not yet seen on the result port
    t_pixel expected_pixels[$];

    // bookkeeping
    int unsigned fail_count     = 0;
    int unsigned lines_accepted = 0;
    int unsigned pixels_seen    = 0;
    int unsigned inside_seen    = 0;
    int unsigned frame_writes   = 0;
    int unsigned stall_cycles   = 0;
    // random gaps on the command side are switched per phase
    bit          idle_enable    = 1'b0;

    line_pixel_stepper #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_pixel_color (i_pixel_color),
        .o_strobe      (o_strobe),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_inside_res  (o_inside_res),
        .o_point_color (o_point_color),
        .o_last_point  (o_last_point),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // period of 2 time units
    always #1 i_clk = ~i_clk;

    // predict the full run of pixels for one line and queue them in order
    task automatic rasterize_line(input t_coord x1, input t_coord y1, input t_coord x2,
                                  input t_coord y2, input t_color color);
        t_coord      cx;
        t_coord      cy;
        int unsigned dx;
        int unsigned dy;
        int unsigned major;
        int unsigned minor;
        logic [7:0]  err;
        logic        x_down;
        logic        y_down;
        logic        x_is_major;
        logic        minor_step;
        cx = x1;
        cy = y1;
        // a coordinate steps down unless its start is below its end
        x_down = !(x1 < x2);
        y_down = !(y1 < y2);
        dx = (x1 < x2) ? x2 - x1 : x1 - x2;
        dy = (y1 < y2) ? y2 - y1 : y1 - y2;
        // ties and single points go y major
        x_is_major = dx > dy;
        major = x_is_major ? dx : dy;
        minor = x_is_major ? dy : dx;
        err = major / 2;
        for (int unsigned k = 0; k <= major; k++) begin
            if (k != 0) begin
                err = err + minor;
                // the minor axis moves only when the error strictly passes the span
                minor_step = err > major;
                if (minor_step) begin
                    err = err - major;
                end
                if (x_is_major) begin
                    cx = x_down ? cx - 1'b1 : cx + 1'b1;
                    if (minor_step) begin
                        cy = y_down ? cy - 1'b1 : cy + 1'b1;
                    end
                end else begin
                    cy = y_down ? cy - 1'b1 : cy + 1'b1;
                    if (minor_step) begin
                        cx = x_down ? cx - 1'b1 : cx + 1'b1;
                    end
                end
            end
            expected_pixels.push_back('{x: cx, y: cy,
                                        in_frame: (cx < frame_w) && (cy < frame_h),
                                        color: color, last: (k == major)});
        end
    endtask

    // result checking, prediction on each accepted line and register tracking,
    // all from values sampled at the rising edge
    always @(posedge i_clk) begin : monitor
        t_pixel want;
        if (i_rst_n) begin
            // check first: a pixel is never due on the edge that takes its line
            if (o_strobe) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel (%0d, %0d) shown with no line pending", o_point_x, o_point_y);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_point_x !== want.x) begin
                        $error("point_x: expected %0d, got %0d", want.x, o_point_x);
                        fail_count++;
                    end
                    if (o_point_y !== want.y) begin
                        $error("point_y: expected %0d, got %0d", want.y, o_point_y);
                        fail_count++;
                    end
                    if (o_inside_res !== want.in_frame) begin
                        $error("inside_res: expected %0b, got %0b", want.in_frame,
                               o_inside_res);
                        fail_count++;
                    end
                    if (o_point_color !== want.color) begin
                        $error("point_color: expected %06h, got %06h", want.color,
                               o_point_color);
                        fail_count++;
                    end
                    if (o_last_point !== want.last) begin
                        $error("last_point: expected %0b, got %0b", want.last, o_last_point);
                        fail_count++;
                    end
                    pixels_seen++;
                    if (want.in_frame) begin
                        inside_seen++;
                    end
                end
            end
            // line command transfer
            if (start && !busy) begin
                rasterize_line(i_start_x, i_start_y, i_end_x, i_end_y, i_pixel_color);
                lines_accepted++;
            end
            // register write transfer
            if (i_cfg_valid && o_cfg_ready) begin
                case (lps_pkg::t_cfg_reg'(i_cfg_index))
                    lps_pkg::CFG_FRAME_WIDTH: begin
                        frame_w = i_cfg_data;
                    end
                    lps_pkg::CFG_FRAME_HEIGHT: begin
                        frame_h = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
                frame_writes++;
            end
        end
    end

    // watchdog: any transfer or pixel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // send one line command; start stays high into the next call so back to
    // back lines need no extra assignment in between
    task automatic send_line(input t_coord x1, input t_coord y1, input t_coord x2,
                             input t_coord y2, input t_color color);
        int unsigned gap;
        // occasional gap with start low, landing anywhere in the previous line
        if (idle_enable && $urandom_range(99, 0) < 7) begin
            gap = $urandom_range(12, 1);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_start_x     <= x1;
        i_start_y     <= y1;
        i_end_x       <= x2;
        i_end_y       <= y2;
        i_pixel_color <= color;
        // held until the block is free at a rising edge
        do @(posedge i_clk); while (busy);
    endtask

    // random line: mostly short spans, some across the whole frame, a few points
    task automatic send_random_line();
        t_coord      x1;
        t_coord      y1;
        int          x2;
        int          y2;
        int unsigned pick;
        x1 = $urandom_range(63, 0);
        y1 = $urandom_range(63, 0);
        pick = $urandom_range(99, 0);
        if (pick < 5) begin
            x2 = x1;
            y2 = y1;
        end else if (pick < 65) begin
            x2 = int'(x1) + int'($urandom_range(16, 0)) - 8;
            y2 = int'(y1) + int'($urandom_range(16, 0)) - 8;
            x2 = (x2 < 0) ? 0 : (x2 > 63) ? 63 : x2;
            y2 = (y2 < 0) ? 0 : (y2 > 63) ? 63 : y2;
        end else begin
            x2 = $urandom_range(63, 0);
            y2 = $urandom_range(63, 0);
        end
        send_line(x1, y1, t_coord'(x2), t_coord'(y2), t_color'($urandom()));
    endtask

    // lower start and wait until every predicted pixel has been seen
    task automatic drain_pixels();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write transfer
    task automatic write_frame_reg(input lps_pkg::t_cfg_reg which, input t_frame value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // frame size changes only once the block has gone quiet
    task automatic set_frame(input t_frame w, input t_frame h);
        drain_pixels();
        write_frame_reg(lps_pkg::CFG_FRAME_WIDTH, w);
        write_frame_reg(lps_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    // hand-picked lines under the reset frame of 64x64
    task automatic test_directed_lines();
        idle_enable = 1'b0;
        // degenerate lines at both corners, colour extremes
        send_line(0, 0, 0, 0, 24'h000000);
        send_line(63, 63, 63, 63, 24'hFFFFFF);
        // full span along each axis, both directions
        send_line(0, 0, 63, 0, 24'hFF0000);
        send_line(63, 17, 0, 17, 24'h00FF00);
        send_line(9, 0, 9, 63, 24'h0000FF);
        send_line(42, 63, 42, 0, 24'hAAAAAA);
        // diagonals: equal spans go y major
        send_line(0, 0, 63, 63, 24'h555555);
        send_line(63, 0, 0, 63, 24'h123456);
        send_line(0, 63, 63, 0, 24'hEDCBA9);
        // shallow and steep with both signs
        send_line(3, 5, 60, 20, 24'h0F0F0F);
        send_line(50, 2, 40, 61, 24'hF0F0F0);
        // tiny lines where the error sits right at the span
        send_line(10, 10, 11, 12, 24'h00FFFF);
        send_line(20, 20, 22, 21, 24'hFF00FF);
        send_line(5, 5, 6, 5, 24'hFFFF00);
    endtask

    // zero, one and above-range frame sizes
    task automatic test_frame_extremes();
        idle_enable = 1'b0;
        // zero width: nothing inside
        set_frame(0, 64);
        send_line(0, 0, 63, 63, 24'h112233);
        send_line(0, 40, 63, 40, 24'h445566);
        // zero height: nothing inside
        set_frame(64, 0);
        send_line(63, 0, 0, 63, 24'h778899);
        send_line(30, 0, 30, 63, 24'hAABBCC);
        // all bits set: everything inside
        set_frame(127, 127);
        send_line(63, 63, 0, 0, 24'hDDEEFF);
        send_line(0, 0, 0, 0, 24'h010203);
        // single pixel frame: only the origin is inside
        set_frame(1, 1);
        send_line(0, 0, 2, 1, 24'h808080);
        send_line(1, 1, 0, 0, 24'h7F7F7F);
    endtask

    // random phases under different frames
    task automatic test_random_lines();
        // reset sized frame with no gaps at all
        set_frame(64, 64);
        idle_enable = 1'b0;
        repeat (100) send_random_line();
        // partial frame, gaps on
        set_frame(t_frame'($urandom_range(64, 1)), t_frame'($urandom_range(64, 1)));
        idle_enable = 1'b1;
        repeat (100) send_random_line();
        // wide but one row high
        set_frame(127, 1);
        repeat (60) send_random_line();
        // anything the register holds
        set_frame(t_frame'($urandom_range(127, 0)), t_frame'($urandom_range(127, 0)));
        repeat (108) send_random_line();
    endtask

    // sender stops until the block has finished everything, then resumes
    task automatic test_pause_until_empty();
        set_frame(40, 24);
        idle_enable = 1'b1;
        repeat (20) send_random_line();
        drain_pixels();
        repeat (20) send_random_line();
    endtask

    initial begin
        // reset held low from time zero, released on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_lines();
        test_frame_extremes();
        test_random_lines();
        test_pause_until_empty();
        drain_pixels();

        $display("covered %0d lines and %0d pixels, %0d of them inside the frame",
                 lines_accepted, pixels_seen, inside_seen);
        $display("frame registers written %0d times, sizes from zero to full scale",
                 frame_writes);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
